[hw/rtl/pjcm_pkg.sv]
// ----------------------------------------------------------------------------
// pjcm_pkg - shared types and constants
// widths of the step-distance datapath and the window control group
// ----------------------------------------------------------------------------
package pjcm_pkg;

	// coordinate and difference widths
	localparam int unsigned POS_W   = 32;
	localparam int unsigned DIFF_W  = 24;
	localparam int unsigned SQ_W    = 2 * DIFF_W;
	// sum of three squares needs two more bits
	localparam int unsigned RAD_W   = SQ_W + 2;
	localparam int unsigned ROOT_W  = RAD_W / 2;
	localparam int unsigned TOTAL_W = 32;
	localparam int unsigned LIMIT_W = 16;

	localparam logic [DIFF_W-1:0]  DIFF_MAX      = '1;
	localparam logic [LIMIT_W-1:0] AVG_LIMIT_RST = 16'd2000;

	// control beat from the sequencer into the window store
	typedef struct packed {
		logic rd;   // fetch the oldest entry
		logic wr;   // push the new distance and update the sum
	} win_ctrl_t;

endpackage

[hw/rtl/pjcm_sqrt.sv]
// ----------------------------------------------------------------------------
// pjcm_sqrt - iterative floor square root
// one result bit per cycle, two radicand bits shifted in per step
// ----------------------------------------------------------------------------
module pjcm_sqrt
	import pjcm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic              busy,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int unsigned STEPS = ROOT_W;
	localparam int unsigned CNT_W = $clog2(STEPS + 1);
	localparam int unsigned REM_W = ROOT_W + 2;
	localparam int unsigned SH_W  = REM_W + 2;

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;

	logic [SH_W-1:0]   rem_sh;
	logic [SH_W-1:0]   trial;
	logic [SH_W-1:0]   rem_diff;
	logic              take;

	// one restoring step
	always_comb begin
		rem_sh   = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial    = {{(SH_W-ROOT_W-2){1'b0}}, root_q, 2'b01};
		rem_diff = rem_sh - trial;
		take     = (rem_sh >= trial);
	end

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// remainder, root and radicand shift
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (take) begin
				rem_q  <= rem_diff[REM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[REM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign done = done_q;
	assign root = root_q;

endmodule

[hw/rtl/pjcm_window.sv]
// ----------------------------------------------------------------------------
// pjcm_window - ring of recent step distances with running sum
// holds the distance ring, write slot, push count and window total
// ----------------------------------------------------------------------------
module pjcm_window
	import pjcm_pkg::*;
#(
	parameter int unsigned WINDOW = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  win_ctrl_t          ctrl,
	input  logic [ROOT_W-1:0]  step_len,
	input  logic [LIMIT_W-1:0] avg_limit,
	output logic               converged
);

	localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned CNT_W  = $clog2(WINDOW + 2);

	logic [ROOT_W-1:0]  ring_mem [WINDOW];
	logic [ROOT_W-1:0]  rd_data_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [CNT_W-1:0]   pushes_q;
	logic [TOTAL_W-1:0] total_q;

	logic               full;
	logic [TOTAL_W-1:0] drop;
	logic [TOTAL_W-1:0] limit_sum;

	// ring storage, oldest entry fetched before the push into the same slot
	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			ring_mem[slot_q] <= step_len;
		end
		if (ctrl.rd) begin
			rd_data_q <= ring_mem[slot_q];
		end
	end

	assign full = (pushes_q >= CNT_W'(WINDOW));
	assign drop = full ? {{(TOTAL_W-ROOT_W){1'b0}}, rd_data_q} : '0;

	// slot, push count and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			pushes_q <= '0;
			total_q  <= '0;
		end else if (ctrl.wr) begin
			total_q <= total_q - drop + {{(TOTAL_W-ROOT_W){1'b0}}, step_len};
			if (slot_q == SLOT_W'(WINDOW - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + SLOT_W'(1);
			end
			if (pushes_q <= CNT_W'(WINDOW)) begin
				pushes_q <= pushes_q + CNT_W'(1);
			end
		end
	end

	// mean test without a divide: total against limit times window
	assign limit_sum = {{(TOTAL_W-LIMIT_W){1'b0}}, avg_limit} * TOTAL_W'(WINDOW);
	assign converged = (pushes_q > CNT_W'(WINDOW)) && (total_q <= limit_sum);

endmodule

[hw/rtl/position_jump_convergence_monitor_core.sv]
// ----------------------------------------------------------------------------
// position_jump_convergence_monitor_core - windowed step-distance monitor
// sequence: a beat is taken in idle, then differences, shared squaring, the
//   25-step square root, window read and push, and output (straight from
//   differences when both positions are zero); s_tready is high only in idle,
//   also while a result waits for m_tready, and low until output is left
// reset: arst_n clears previous position, window state and output valid;
//   avg_limit returns to 2000
// ----------------------------------------------------------------------------
module position_jump_convergence_monitor_core
	import pjcm_pkg::*;
#(
	parameter int unsigned WINDOW = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	// pos_x [31:0], pos_y [63:32], pos_z [95:64]
	input  logic [95:0]        s_tdata,
	input  logic               s_tvalid,
	output logic               s_tready,
	// converged [0], zero fill [7:1]
	output logic [7:0]         m_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata
);

	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_DIFF      = 8'b0000_0010,
		S_SQ        = 8'b0000_0100,
		S_ROOT_GO   = 8'b0000_1000,
		S_ROOT_WAIT = 8'b0001_0000,
		S_RD        = 8'b0010_0000,
		S_WR        = 8'b0100_0000,
		S_OUT       = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic [LIMIT_W-1:0]  avg_limit_q;
	logic [POS_W-1:0]    cur_x_q, cur_y_q, cur_z_q;
	logic [POS_W-1:0]    prev_x_q, prev_y_q, prev_z_q;
	logic [DIFF_W-1:0]   dx_q, dy_q, dz_q;
	logic [1:0]          sq_cnt_q;
	logic [SQ_W-1:0]     prod_q;
	logic [RAD_W-1:0]    acc_q;
	logic                zero_q;
	logic                m_tvalid_q;
	logic                m_conv_q;

	logic [DIFF_W-1:0]   sq_sel;
	logic [SQ_W-1:0]     sq_val;
	logic                root_start;
	logic                root_busy;
	logic                root_done;
	logic [ROOT_W-1:0]   root_val;
	win_ctrl_t           win_ctrl;
	logic                win_conv;
	logic                out_free;
	logic                both_zero;

	// saturated magnitude of a coordinate difference
	function automatic logic [DIFF_W-1:0] sat_abs_diff(input logic [POS_W-1:0] a,
			input logic [POS_W-1:0] b);
		logic [POS_W:0] d;
		logic [POS_W:0] m;
		d = {a[POS_W-1], a} - {b[POS_W-1], b};
		m = d[POS_W] ? (~d + (POS_W+1)'(1)) : d;
		if (m > {{(POS_W+1-DIFF_W){1'b0}}, DIFF_MAX}) begin
			sat_abs_diff = DIFF_MAX;
		end else begin
			sat_abs_diff = m[DIFF_W-1:0];
		end
	endfunction

	assign s_tready  = (state_q == S_IDLE);
	assign out_free  = !m_tvalid_q || m_tready;
	assign both_zero = (cur_x_q == '0) && (cur_y_q == '0) && (cur_z_q == '0) &&
		(prev_x_q == '0) && (prev_y_q == '0) && (prev_z_q == '0);

	// shared squaring unit operand select
	always_comb begin
		unique case (sq_cnt_q)
			2'd0:    sq_sel = dx_q;
			2'd1:    sq_sel = dy_q;
			default: sq_sel = dz_q;
		endcase
		sq_val = sq_sel * sq_sel;
	end

	assign root_start = (state_q == S_ROOT_GO);
	assign win_ctrl.rd = (state_q == S_RD);
	assign win_ctrl.wr = (state_q == S_WR);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_limit_q <= AVG_LIMIT_RST;
		end else if (cfg_we) begin
			avg_limit_q <= cfg_wdata;
		end
	end

	// sequencer, previous position and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			sq_cnt_q   <= '0;
			zero_q     <= 1'b0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			prev_z_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					sq_cnt_q <= '0;
					zero_q   <= both_zero;
					state_q  <= both_zero ? S_OUT : S_SQ;
				end
				S_SQ: begin
					sq_cnt_q <= sq_cnt_q + 2'd1;
					if (sq_cnt_q == 2'd3) begin
						state_q <= S_ROOT_GO;
					end
				end
				S_ROOT_GO: begin
					state_q <= S_ROOT_WAIT;
				end
				S_ROOT_WAIT: begin
					if (root_done) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					prev_x_q <= cur_x_q;
					prev_y_q <= cur_y_q;
					prev_z_q <= cur_z_q;
					state_q  <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cur_x_q <= s_tdata[31:0];
			cur_y_q <= s_tdata[63:32];
			cur_z_q <= s_tdata[95:64];
		end
		if (state_q == S_DIFF) begin
			dx_q <= sat_abs_diff(cur_x_q, prev_x_q);
			dy_q <= sat_abs_diff(cur_y_q, prev_y_q);
			dz_q <= sat_abs_diff(cur_z_q, prev_z_q);
		end
		// square one coordinate per cycle, accumulate the previous product
		if (state_q == S_SQ) begin
			prod_q <= sq_val;
			if (sq_cnt_q == 2'd0) begin
				acc_q <= '0;
			end else begin
				acc_q <= acc_q + {2'b00, prod_q};
			end
		end
		if ((state_q == S_OUT) && out_free) begin
			m_conv_q <= win_conv && !zero_q;
		end
	end

	pjcm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (acc_q),
		.busy     (root_busy),
		.done     (root_done),
		.root     (root_val)
	);

	pjcm_window #(
		.WINDOW (WINDOW)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (win_ctrl),
		.step_len  (root_val),
		.avg_limit (avg_limit_q),
		.converged (win_conv)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b000_0000, m_conv_q};

	// no new beat is taken while the root unit iterates
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		root_busy |-> !s_tready)
		else $error("input accepted during square root");

	// root completes only while the sequencer waits for it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> (state_q == S_ROOT_WAIT))
		else $error("square root done outside wait state");

	// an output beat is raised only from the output state
	a_out_from_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == S_OUT))
		else $error("output beat raised outside output state");

	// window push happens only with a fresh root
	a_push_after_root: assert property (@(posedge clk) disable iff (!arst_n)
		win_ctrl.wr |-> $past(win_ctrl.rd, 1) && $past(root_done, 2))
		else $error("window push without completed root");

endmodule
